// ----- sv/min_tracking_stack_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Min tracking stack assertion macros
// Checks for the min tracking stack unit, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_UNIT_ASSERT_SVH
`define MIN_TRACKING_STACK_UNIT_ASSERT_SVH

// Condition that must hold at every rising edge outside reset.
`define MSU_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define MSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/msu_pkg.sv -----
// ----------------------------------------------------------------------------
// Min tracking stack package
// Command and status codes, fixed field widths and the control word that
// travels from the controller to the result stage.
// ----------------------------------------------------------------------------
package msu_pkg;

	localparam int unsigned CMD_W = 2;
	localparam int unsigned ST_W  = 2;
	localparam int unsigned CNT_W = 7;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PEEK = 2'd2
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_BADPOS    = 2'd3
	} status_t;

	typedef struct packed {
		status_t status;
		logic    empty;
		logic    full;
		logic    data_sel;     // data comes from the value memory read
		logic    min_from_mem; // minimum comes from the min memory read
	} s1_ctl_t;

endpackage

// ----- sv/min_tracking_stack_unit.sv -----
// A command waits in flight for its memory read, then enters the output register.
// Throughput: one command per cycle unless the output stalls; the memory read of a
// pop or peek and the output register overlap with the decode of the next command.
// Reset clears the count, the pipeline valids and sets the capacity to 64;
// the value and minimum memories are not cleared and need no clearing pass.
`include "min_tracking_stack_unit_assert.svh"
// ----------------------------------------------------------------------------
// Min tracking stack unit
// A stack of signed values that reports the smallest value held with every
// result. Push, pop and peek commands arrive one per beat.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [msu_pkg::CNT_W-1:0]    cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [msu_pkg::CMD_W-1:0]    cmd,
	input  logic signed [DATA_WIDTH-1:0] push_value,
	input  logic [msu_pkg::CNT_W-1:0]    position,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] data_out,
	output logic signed [DATA_WIDTH-1:0] min_value,
	output logic [msu_pkg::CNT_W-1:0]    entry_count,
	output logic [msu_pkg::ST_W-1:0]     status,
	output logic                         is_empty,
	output logic                         is_full
);

	import msu_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	// Memory ports. Both memories share the write address: a push writes the
	// value and the running minimum into the same slot.
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [DATA_WIDTH-1:0]        val_wdata;
	logic [DATA_WIDTH-1:0]        min_wdata;
	logic                         rd_en;
	logic [AW-1:0]                val_raddr;
	logic [AW-1:0]                min_raddr;
	logic [DATA_WIDTH-1:0]        val_rdata;
	logic [DATA_WIDTH-1:0]        min_rdata;

	// Command in flight, waiting for its read data.
	logic                         s1_valid;
	s1_ctl_t                      s1_ctl;
	logic [CW-1:0]                s1_count;
	logic signed [DATA_WIDTH-1:0] s1_min;

	// Output register.
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] data_out_q;
	logic signed [DATA_WIDTH-1:0] min_value_q;
	logic [CNT_W-1:0]             entry_count_q;
	status_t                      status_q;
	logic                         is_empty_q;
	logic                         is_full_q;

	logic                         out_free;
	logic                         out_load;

	// The output register can take a new beat when it is empty or its
	// current beat leaves at this edge.
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = s1_valid && out_free;

	msu_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.push_value  (push_value),
		.position    (position),
		.out_free    (out_free),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.val_wdata   (val_wdata),
		.min_wdata   (min_wdata),
		.rd_en       (rd_en),
		.val_raddr   (val_raddr),
		.min_raddr   (min_raddr),
		.min_rdata   (min_rdata),
		.s1_valid    (s1_valid),
		.s1_ctl      (s1_ctl),
		.s1_count    (s1_count),
		.s1_min      (s1_min)
	);

	// Value memory: a pop reads the top slot, a peek reads the slot the
	// position points at.
	msu_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_val_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (val_wdata),
		.rd_en   (rd_en),
		.rd_addr (val_raddr),
		.rd_data (val_rdata)
	);

	// Minimum memory: a pop reads the slot below the top, which holds the
	// minimum of what remains after the pop.
	msu_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_WIDTH)
	) u_min_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (min_wdata),
		.rd_en   (rd_en),
		.rd_addr (min_raddr),
		.rd_data (min_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The read data stays on the memory outputs until the next command is
	// accepted, and that cannot happen before this beat moves on.
	always_ff @(posedge clk) begin
		if (out_load) begin
			data_out_q    <= s1_ctl.data_sel ? $signed(val_rdata) : '0;
			min_value_q   <= s1_ctl.min_from_mem ? $signed(min_rdata) : s1_min;
			entry_count_q <= CNT_W'(s1_count);
			status_q      <= s1_ctl.status;
			is_empty_q    <= s1_ctl.empty;
			is_full_q     <= s1_ctl.full;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_out    = data_out_q;
	assign min_value   = min_value_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;
	assign is_empty    = is_empty_q;
	assign is_full     = is_full_q;

	// A rejected push leaves the stack at or above its capacity.
	`MSU_ASSERT_IMPLY(a_overflow_full, out_valid && status == ST_OVERFLOW, is_full, "overflow beat without full flag")
	// An underflow only happens on an empty stack and returns no data.
	`MSU_ASSERT_IMPLY(a_underflow_empty, out_valid && status == ST_UNDERFLOW, is_empty && data_out == '0, "underflow beat not empty or with data")
	// An empty stack reports a zero minimum.
	`MSU_ASSERT_IMPLY(a_empty_min_zero, out_valid && is_empty, min_value == '0 && entry_count == '0, "empty beat with nonzero minimum or count")
	// The input side only stalls when a result is held up at the output.
	`MSU_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stalled while output is free")

endmodule

// ----- sv/msu_ram.sv -----
// ----------------------------------------------------------------------------
// Min tracking stack memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module msu_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/msu_ctrl.sv -----
// ----------------------------------------------------------------------------
// Min tracking stack controller
// Holds the count, the capacity and the running minimum, decodes each beat,
// drives the memory ports and keeps one command in flight for the read.
// ----------------------------------------------------------------------------
module msu_ctrl #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned AW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [msu_pkg::CNT_W-1:0]         cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [msu_pkg::CMD_W-1:0]         cmd,
	input  logic signed [DATA_WIDTH-1:0]      push_value,
	input  logic [msu_pkg::CNT_W-1:0]         position,
	input  logic                              out_free,
	output logic                              wr_en,
	output logic [AW-1:0]                     wr_addr,
	output logic [DATA_WIDTH-1:0]             val_wdata,
	output logic [DATA_WIDTH-1:0]             min_wdata,
	output logic                              rd_en,
	output logic [AW-1:0]                     val_raddr,
	output logic [AW-1:0]                     min_raddr,
	input  logic signed [DATA_WIDTH-1:0]      min_rdata,
	output logic                              s1_valid,
	output msu_pkg::s1_ctl_t                  s1_ctl,
	output logic [CW-1:0]                     s1_count,
	output logic signed [DATA_WIDTH-1:0]      s1_min
);

	import msu_pkg::*;

	localparam int unsigned XW = (CW > CNT_W) ? CW : CNT_W;

	logic [CNT_W-1:0]             capacity_q;
	logic [CW-1:0]                count_q;
	logic signed [DATA_WIDTH-1:0] top_min_q;
	logic                         s1_valid_s1;
	s1_ctl_t                      s1_ctl_s1;
	logic [CW-1:0]                s1_count_s1;
	logic signed [DATA_WIDTH-1:0] s1_min_s1;

	logic                         accept;
	logic                         s1_move;
	logic signed [DATA_WIDTH-1:0] top_min_cur;
	logic signed [DATA_WIDTH-1:0] push_min;
	logic [XW-1:0]                count_x;
	logic [XW-1:0]                pos_x;
	logic [XW-1:0]                cap_x;
	logic [XW-1:0]                cap_eff;
	logic [CW-1:0]                count_nxt;
	logic                         push_ok;
	logic                         rd_req;
	s1_ctl_t                      ctl_nxt;
	logic signed [DATA_WIDTH-1:0] min_nxt;

	assign s1_move  = s1_valid_s1 && out_free;
	assign in_stall = s1_valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// A pop still in flight has the new top minimum on the min read port.
	assign top_min_cur = (s1_valid_s1 && s1_ctl_s1.min_from_mem) ? min_rdata : top_min_q;
	assign push_min = (count_q != '0 && top_min_cur < push_value) ? top_min_cur : push_value;

	assign count_x = XW'(count_q);
	assign pos_x   = XW'(position);
	assign cap_x   = XW'(capacity_q);
	assign cap_eff = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;

	always_comb begin
		count_nxt            = count_q;
		push_ok              = 1'b0;
		rd_req               = 1'b0;
		ctl_nxt.status       = ST_OK;
		ctl_nxt.data_sel     = 1'b0;
		ctl_nxt.min_from_mem = 1'b0;
		min_nxt              = (count_q != '0) ? top_min_cur : '0;
		val_raddr            = AW'(count_x - pos_x);
		min_raddr            = AW'(count_x - XW'(2));
		unique case (cmd)
			CMD_PUSH: begin
				if (count_x >= cap_eff) begin
					ctl_nxt.status = ST_OVERFLOW;
				end else begin
					push_ok   = 1'b1;
					count_nxt = count_q + CW'(1);
					min_nxt   = push_min;
				end
			end
			CMD_POP: begin
				val_raddr = AW'(count_x - XW'(1));
				if (count_q == '0) begin
					ctl_nxt.status = ST_UNDERFLOW;
				end else begin
					rd_req           = 1'b1;
					count_nxt        = count_q - CW'(1);
					ctl_nxt.data_sel = 1'b1;
					if (count_q > CW'(1)) begin
						ctl_nxt.min_from_mem = 1'b1;
					end else begin
						min_nxt = '0;
					end
				end
			end
			CMD_PEEK: begin
				if (position == '0 || pos_x > count_x) begin
					ctl_nxt.status = ST_BADPOS;
				end else begin
					rd_req           = 1'b1;
					ctl_nxt.data_sel = 1'b1;
				end
			end
			default: begin
			end
		endcase
		ctl_nxt.empty = (count_nxt == '0);
		ctl_nxt.full  = (XW'(count_nxt) >= cap_eff);
	end

	assign wr_en     = accept && push_ok;
	assign wr_addr   = AW'(count_q);
	assign val_wdata = push_value;
	assign min_wdata = push_min;
	assign rd_en     = accept && rd_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (accept) begin
				count_q     <= count_nxt;
				s1_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && push_ok) begin
			top_min_q <= push_min;
		end else if (s1_move && s1_ctl_s1.min_from_mem) begin
			top_min_q <= min_rdata;
		end
		if (accept) begin
			s1_ctl_s1   <= ctl_nxt;
			s1_count_s1 <= count_nxt;
			s1_min_s1   <= min_nxt;
		end
	end

	assign s1_valid = s1_valid_s1;
	assign s1_ctl   = s1_ctl_s1;
	assign s1_count = s1_count_s1;
	assign s1_min   = s1_min_s1;

endmodule

// ----- dv/min_tracking_stack_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min tracking stack result checker
// Watches command, result and capacity beats. It keeps its own copy of the
// stack and the running minimum, and compares every result field in order.
// ----------------------------------------------------------------------------
module min_tracking_stack_checker #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [msu_pkg::CNT_W-1:0]    cfg_wr_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [msu_pkg::CMD_W-1:0]    cmd,
	input  logic signed [DATA_WIDTH-1:0] push_value,
	input  logic [msu_pkg::CNT_W-1:0]    position,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [DATA_WIDTH-1:0] data_out,
	input  logic signed [DATA_WIDTH-1:0] min_value,
	input  logic [msu_pkg::CNT_W-1:0]    entry_count,
	input  logic [msu_pkg::ST_W-1:0]     status,
	input  logic                         is_empty,
	input  logic                         is_full,
	output int unsigned                  fail_count,
	output int unsigned                  outstanding,
	output int unsigned                  checked
);

	import msu_pkg::*;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] data;
		logic signed [DATA_WIDTH-1:0] least;
		logic [CNT_W-1:0]             count;
		status_t                      st;
		logic                         empty;
		logic                         full;
	} stack_result_t;

	logic signed [DATA_WIDTH-1:0] held_value [DEPTH];
	logic signed [DATA_WIDTH-1:0] held_least [DEPTH];
	int unsigned                  level;
	int unsigned                  cap_reg;
	stack_result_t                result_q [$];
	int unsigned                  fails;
	int unsigned                  seen;

	// Applies one command to the private stack and returns the result it should produce.
	function automatic stack_result_t predict_stack_op(input logic [CMD_W-1:0] op,
			input logic signed [DATA_WIDTH-1:0] value, input logic [CNT_W-1:0] pos);
		int unsigned   limit;
		stack_result_t r;
		limit = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		r = '0;
		r.st = ST_OK;
		case (op)
		CMD_PUSH: begin
			if (level >= limit || level >= DEPTH) begin
				r.st = ST_OVERFLOW;
			end else begin
				held_value[level] = value;
				held_least[level] = (level > 0 && held_least[level-1] < value) ?
					held_least[level-1] : value;
				level++;
			end
		end
		CMD_POP: begin
			if (level == 0) begin
				r.st = ST_UNDERFLOW;
			end else begin
				level--;
				r.data = held_value[level];
			end
		end
		CMD_PEEK: begin
			if (pos == 0 || pos > level)
				r.st = ST_BADPOS;
			else
				r.data = held_value[level-pos];
		end
		default: ;
		endcase
		r.least = (level > 0) ? held_least[level-1] : '0;
		r.count = CNT_W'(level);
		r.empty = (level == 0);
		r.full  = (level >= limit);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		stack_result_t want;
		if (!arst_n) begin
			level = 0;
			cap_reg = CAP_RESET;
			result_q.delete();
			fails = 0;
			seen = 0;
			fail_count <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			// Results are taken first: a result never shares an edge with its own command.
			if (out_valid && !out_stall) begin
				seen++;
				if (result_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("[%0t] result beat with no command waiting: data %0d min %0d",
							$realtime, data_out, min_value);
				end else begin
					want = result_q.pop_front();
					if (data_out !== want.data || min_value !== want.least ||
							entry_count !== want.count || status !== want.st ||
							is_empty !== want.empty || is_full !== want.full) begin
						fails++;
						if (fails <= 10) begin
							$display("[%0t] mismatch on result %0d", $realtime, seen);
							$display("  expected data %0d min %0d count %0d st %0d empty %0b full %0b",
								want.data, want.least, want.count, want.st, want.empty, want.full);
							$display("  actual   data %0d min %0d count %0d st %0d empty %0b full %0b",
								data_out, min_value, entry_count, status, is_empty, is_full);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(predict_stack_op(cmd, push_value, position));
			if (cfg_wr_en)
				cap_reg = cfg_wr_data;
			fail_count <= fails;
			checked <= seen;
			outstanding <= result_q.size();
		end
	end

endmodule

// ----- dv/min_tracking_stack_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min tracking stack unit testbench
// Drives push, pop, peek and unused command beats through the stack under a
// series of capacity settings, with random idling on both channels and one
// long output hold-off. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit_tb;

	import msu_pkg::*;

	localparam int unsigned DEPTH      = 64;
	localparam int unsigned DATA_WIDTH = 32;

	// The command field is two bits wide; the code left over is not a valid
	// operation, and the block must answer it with an OK result that changes nothing.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Margin waited after the last result has come back, before a capacity write
	// and at the end of the run.
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES   = 160;
	localparam int unsigned SEGMENTS      = 14;
	localparam int unsigned SEGMENT_BEATS = 100;
	localparam int unsigned RUN_LIMIT_NS  = 200000;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_wr_en   = 1'b0;
	logic [CNT_W-1:0]             cfg_wr_data = '0;
	logic                         in_valid    = 1'b0;
	logic                         in_stall;
	logic [CMD_W-1:0]             cmd         = '0;
	logic signed [DATA_WIDTH-1:0] push_value  = '0;
	logic [CNT_W-1:0]             position    = '0;
	logic                         out_valid;
	logic                         out_stall   = 1'b0;
	logic signed [DATA_WIDTH-1:0] data_out;
	logic signed [DATA_WIDTH-1:0] min_value;
	logic [CNT_W-1:0]             entry_count;
	logic [ST_W-1:0]              status;
	logic                         is_empty;
	logic                         is_full;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned checked;

	// Idling is switched off for one whole segment so that back-to-back beats
	// run on both channels for a long stretch.
	bit quiet = 1'b0;

	// The stimulus side asks for a long output hold-off by bumping the request
	// count; the output process serves it and counts its own cycles.
	int unsigned hold_requests = 0;
	int unsigned holds_done    = 0;

	// Rough idea of the stack depth, only used to aim peek positions.
	int unsigned est_depth = 0;
	int unsigned est_cap   = DEPTH;

	int unsigned n_push   = 0;
	int unsigned n_pop    = 0;
	int unsigned n_peek   = 0;
	int unsigned n_unused = 0;
	int unsigned n_cfg    = 0;

	int unsigned seg_cap  [SEGMENTS] = '{127, 64, 1, 0, 5, 64, 33, 2, 64, 17, 127, 64, 3, 64};
	int unsigned seg_push [SEGMENTS] = '{60, 85, 50, 45, 55, 50, 65, 50, 35, 60, 80, 55, 50, 30};

	min_tracking_stack_unit #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.push_value  (push_value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_out    (data_out),
		.min_value   (min_value),
		.entry_count (entry_count),
		.status      (status),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

	min_tracking_stack_checker #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) result_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.push_value  (push_value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_out    (data_out),
		.min_value   (min_value),
		.entry_count (entry_count),
		.status      (status),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Values lean toward the extremes and a narrow band around zero, so that
	// equal values and ties for the minimum come up often.
	function automatic logic signed [DATA_WIDTH-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return VAL_MAX;
		if (r < 8)
			return VAL_MIN;
		if (r < 10)
			return '0;
		if (r < 12)
			return '1;
		if (r < 45)
			return DATA_WIDTH'(int'($urandom_range(0, 40)) - 20);
		return DATA_WIDTH'($urandom);
	endfunction

	// Peek positions mostly land inside the stack, with zero, one past the top
	// and the full seven-bit range mixed in.
	function automatic logic [CNT_W-1:0] pick_position();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return CNT_W'($urandom);
		if (r < 24 || est_depth == 0)
			return CNT_W'(est_depth + 1);
		return CNT_W'($urandom_range(1, est_depth));
	endfunction

	// Offers one command beat and holds it until it is taken. Valid stays high
	// into the next beat unless a random gap is inserted afterwards.
	task automatic offer_beat(input logic [CMD_W-1:0] op,
			input logic signed [DATA_WIDTH-1:0] value, input logic [CNT_W-1:0] pos);
		in_valid   <= 1'b1;
		cmd        <= op;
		push_value <= value;
		position   <= pos;
		do
			@(posedge clk);
		while (in_stall);
		case (op)
		CMD_PUSH: begin
			n_push++;
			if (est_depth < est_cap)
				est_depth++;
		end
		CMD_POP: begin
			n_pop++;
			if (est_depth > 0)
				est_depth--;
		end
		CMD_PEEK: n_peek++;
		default: n_unused++;
		endcase
		if (!quiet && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// One random beat; the push share sets whether the stack tends to grow,
	// hover or drain during a segment.
	task automatic random_beat(input int unsigned push_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			offer_beat(CMD_UNUSED, pick_value(), pick_position());
		else if (r < 3 + push_pct)
			offer_beat(CMD_PUSH, pick_value(), pick_position());
		else if ($urandom_range(0, 99) < 55)
			offer_beat(CMD_POP, pick_value(), pick_position());
		else
			offer_beat(CMD_PEEK, pick_value(), pick_position());
	endtask

	// Drops valid and waits until every expected result has come back, then
	// lets the pipeline run empty.
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Capacity changes are made only while the block is idle.
	task automatic write_capacity(input int unsigned cap);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CNT_W'(cap);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		est_cap = (cap > DEPTH) ? DEPTH : cap;
		n_cfg++;
	endtask

	// Output side: random stalls, plus the long hold-off when asked for one.
	// While it lasts the block fills up and must stall the command channel.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			out_stall <= (!quiet && $urandom_range(0, 99) < 15);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned cap;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack: pop underflows, any peek is out of range, and the unused
		// command comes back OK with nothing changed.
		offer_beat(CMD_POP, '0, '0);
		offer_beat(CMD_PEEK, '0, 7'd1);
		offer_beat(CMD_UNUSED, VAL_MIN, 7'd127);

		// The first push becomes its own minimum; the most negative value then
		// takes over the minimum and keeps it while larger values go on top.
		offer_beat(CMD_PUSH, VAL_MAX, '0);
		offer_beat(CMD_PUSH, VAL_MIN, '0);
		offer_beat(CMD_PUSH, '0, '0);
		offer_beat(CMD_PUSH, '1, '0);

		// Peek at zero, the top, the bottom, one past the bottom and the far end.
		offer_beat(CMD_PEEK, '0, 7'd0);
		offer_beat(CMD_PEEK, '0, 7'd1);
		offer_beat(CMD_PEEK, '0, 7'd4);
		offer_beat(CMD_PEEK, '0, 7'd5);
		offer_beat(CMD_PEEK, '0, 7'd127);

		// Pop everything, watching the minimum go back to the first value and
		// then to zero, and underflow once more at the end.
		repeat (5) offer_beat(CMD_POP, '0, '0);

		// A capacity of one: the second push overflows and the stack reads full.
		write_capacity(1);
		offer_beat(CMD_PUSH, 32'sd7, '0);
		offer_beat(CMD_PUSH, -32'sd8, '0);
		offer_beat(CMD_POP, '0, '0);

		// A capacity of zero: every push overflows and full is set while empty.
		write_capacity(0);
		offer_beat(CMD_PUSH, 32'sd5, '0);
		offer_beat(CMD_POP, '0, '0);

		// Capacity lowered below the count: entries are kept, push overflows,
		// and full only drops once pops bring the count under the capacity.
		write_capacity(DEPTH);
		offer_beat(CMD_PUSH, 32'sd3, '0);
		offer_beat(CMD_PUSH, 32'sd1, '0);
		offer_beat(CMD_PUSH, 32'sd2, '0);
		write_capacity(2);
		offer_beat(CMD_PUSH, 32'sd9, '0);
		offer_beat(CMD_POP, '0, '0);
		offer_beat(CMD_POP, '0, '0);
		offer_beat(CMD_PUSH, -32'sd4, '0);

		// Random segments, each under its own capacity. Capacities above the
		// depth clamp to the depth. Segment 1 fills the stack against a long
		// output hold-off; segment 5 runs with no idling on either side.
		for (int unsigned s = 0; s < SEGMENTS; s++) begin
			cap = (s == 11) ? $urandom_range(1, DEPTH) : seg_cap[s];
			write_capacity(cap);
			if (s == 1)
				hold_requests++;
			quiet = (s == 5);
			repeat (SEGMENT_BEATS) random_beat(seg_push[s]);
		end
		quiet = 1'b0;

		settle();
		$display("Run covered %0d command beats (%0d push, %0d pop, %0d peek, %0d unused)",
			n_push + n_pop + n_peek + n_unused, n_push, n_pop, n_peek, n_unused);
		$display("over %0d capacity writes; %0d result beats compared, %0d failures.",
			n_cfg, checked, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
